@@ hw/rtl/tdbl_pkg.sv @@
// Shared widths, opcodes and state encoding for the tree distance engine.
// No dependencies; imported by tree_distance_binary_lifting.
`default_nettype none

package tdbl_pkg;

   localparam int VERT_W  = 11;
   localparam int DEPTH_W = 10;
   localparam int DIST_W  = 11;

   localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;
   localparam logic [DIST_W-1:0]  DIST_MAX  = '1;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_LFILL = 6'b000010,
      S_QSWAP = 6'b000100,
      S_LIFT  = 6'b001000,
      S_CLIMB = 6'b010000,
      S_FIN   = 6'b100000
   } state_type;

endpackage

`default_nettype wire

@@ hw/rtl/tdbl_ram.sv @@
// Generic synchronous RAM: one write port, two registered read ports.
// Read during write of the same address returns the old contents.
`default_nettype none

module tdbl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
   output logic      [WIDTH-1:0]         rdata_a,
   input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic      [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
   end

endmodule

`default_nettype wire

@@ hw/rtl/tree_distance_binary_lifting.sv @@
// Tree distance engine built on a binary-lifting ancestor table.
// Depends on tdbl_pkg and tdbl_ram.
//
// Usage: a word is accepted when start is high and busy is low. Opcode load
// stores a vertex with its parent (parent 0 marks a root); the parent must be
// loaded first. Opcode query returns the edge count between two vertices as
// one rsp_valid strobe with rsp_distance. Loads return nothing.
//
// A load keeps busy high after acceptance while it fills the ancestor levels
// above level 0, each level a dependent read of the ancestor table. A query
// strobes its result after the depth reads, the lift to equal depth and the
// joint climb, each lift and climb step a single table read whose data steers
// the next address, and a closing state. A query of a vertex with itself
// strobes on the next cycle. The next word may be accepted in the cycle the
// result is shown.
//
// Reset clears only control state; memories are not swept. Vertex 0 reads
// as an all-zero row and depth 0 by masking. The receiver cannot stall: each
// result is shown for exactly one cycle.
`default_nettype none

module tree_distance_binary_lifting
   import tdbl_pkg::*;
#(
   parameter int MAX_VERTICES = 1024,
   parameter int LEVELS       = 11
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic              req_opcode,
   input  wire logic [VERT_W-1:0] req_first_vertex,
   input  wire logic [VERT_W-1:0] req_second_vertex,
   output logic                   rsp_valid,
   output logic      [DIST_W-1:0] rsp_distance
);

   localparam int RV_W      = $clog2(MAX_VERTICES + 1);
   localparam int LW        = $clog2(LEVELS + 1);
   localparam int TBL_DEPTH = (MAX_VERTICES + 1) << LW;
   localparam int TA_W      = RV_W + LW;
   localparam int CW        = (LEVELS + 3 > 12) ? LEVELS + 3 : 12;

   function automatic logic [VERT_W-1:0] clip(input logic [VERT_W-1:0] v);
      return (32'(v) > MAX_VERTICES) ? '0 : v;
   endfunction

   function automatic logic [TA_W-1:0] tbl_addr(input logic [VERT_W-1:0] v,
                                                input logic [LW-1:0] l);
      return {RV_W'(v), l};
   endfunction

   function automatic logic [DIST_W-1:0] sat(input logic [CW-1:0] s);
      return (s > CW'(DIST_MAX)) ? DIST_MAX : s[DIST_W-1:0];
   endfunction

   state_type          state_ff, state_in;
   logic [VERT_W-1:0]  va_ff, va_in, vb_ff, vb_in;
   logic [DEPTH_W-1:0] delta_ff, delta_in;
   logic [DIST_W-1:0]  cnt_ff, cnt_in;
   logic [LW-1:0]      lv_ff, lv_in, lvp_ff, lvp_in;
   logic               pend_lift_ff, pend_lift_in, pend_climb_ff, pend_climb_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0]  rsp_dist_ff, rsp_dist_in;
   logic               tz_a_ff, tz_a_in, tz_b_ff, tz_b_in;
   logic               dz_a_ff, dz_a_in, dz_b_ff, dz_b_in;
   logic               fwd_ff, fwd_in;
   logic [VERT_W-1:0]  fwd_data_ff, fwd_data_in;

   logic               tbl_we;
   logic [TA_W-1:0]    tbl_wa, tbl_ra, tbl_rb;
   logic [VERT_W-1:0]  tbl_wd, tbl_qa, tbl_qb;
   logic [VERT_W-1:0]  ra_vtx;
   logic [LW-1:0]      ra_lvl;
   logic               dep_we;
   logic [RV_W-1:0]    dep_wa;
   logic [DEPTH_W-1:0] dep_wd, dep_qa, dep_qb;

   logic [VERT_W-1:0]  v1c, v2c;
   logic [VERT_W-1:0]  rd_a, rd_b, a_cur, b_cur;
   logic               diff, take;
   logic [DIST_W-1:0]  cnt_cur;
   logic [CW-1:0]      sum_climb, sum_fin;
   logic [DEPTH_W-1:0] da, db, delta_sh;

   assign v1c = clip(req_first_vertex);
   assign v2c = clip(req_second_vertex);

   tdbl_ram #(.WIDTH(VERT_W), .DEPTH(TBL_DEPTH)) u_tbl (
      .clock   (clock),
      .we      (tbl_we),
      .waddr   (tbl_wa),
      .wdata   (tbl_wd),
      .raddr_a (tbl_ra),
      .rdata_a (tbl_qa),
      .raddr_b (tbl_rb),
      .rdata_b (tbl_qb)
   );

   tdbl_ram #(.WIDTH(DEPTH_W), .DEPTH(MAX_VERTICES + 1)) u_dep (
      .clock   (clock),
      .we      (dep_we),
      .waddr   (dep_wa),
      .wdata   (dep_wd),
      .raddr_a (RV_W'(v1c)),
      .rdata_a (dep_qa),
      .raddr_b (RV_W'(v2c)),
      .rdata_b (dep_qb)
   );

   // Row zero is never written and reads as zero. A read that hit the word
   // being written in the same cycle takes the new word on read port a only.
   assign rd_a = clip(tz_a_ff ? '0 : (fwd_ff ? fwd_data_ff : tbl_qa));
   assign rd_b = clip(tz_b_ff ? '0 : tbl_qb);
   assign da   = dz_a_ff ? '0 : dep_qa;
   assign db   = dz_b_ff ? '0 : dep_qb;

   // Settle the step whose table data has just returned.
   assign diff      = rd_a != rd_b;
   assign take      = pend_climb_ff && diff;
   assign a_cur     = (pend_lift_ff || take) ? rd_a : va_ff;
   assign b_cur     = take ? rd_b : vb_ff;
   assign sum_climb = CW'(cnt_ff) + (CW'(2) << lvp_ff);
   assign cnt_cur   = take ? sat(sum_climb) : cnt_ff;
   assign sum_fin   = CW'(cnt_cur) + CW'(2);
   assign delta_sh  = delta_ff >> lv_ff;

   assign tbl_ra = tbl_addr(ra_vtx, ra_lvl);
   assign tbl_rb = tbl_addr(b_cur, lv_ff);

   always_comb begin
      state_in      = state_ff;
      va_in         = va_ff;
      vb_in         = vb_ff;
      delta_in      = delta_ff;
      cnt_in        = cnt_ff;
      lv_in         = lv_ff;
      lvp_in        = lvp_ff;
      pend_lift_in  = 1'b0;
      pend_climb_in = 1'b0;
      rsp_valid_in  = 1'b0;
      rsp_dist_in   = rsp_dist_ff;
      tbl_we        = 1'b0;
      tbl_wa        = tbl_addr(va_ff, lv_ff);
      tbl_wd        = rd_a;
      ra_vtx        = a_cur;
      ra_lvl        = lv_ff;
      dep_we        = 1'b0;
      dep_wa        = RV_W'(va_ff);
      dep_wd        = (dep_qb == DEPTH_MAX) ? DEPTH_MAX : dep_qb + DEPTH_W'(1);

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_opcode == OP_LOAD) begin
                  if (v1c != '0) begin
                     tbl_we   = 1'b1;
                     tbl_wa   = tbl_addr(v1c, '0);
                     tbl_wd   = v2c;
                     ra_vtx   = v2c;
                     ra_lvl   = '0;
                     va_in    = v1c;
                     lv_in    = LW'(1);
                     state_in = S_LFILL;
                  end
               end else if (v1c == v2c) begin
                  rsp_valid_in = 1'b1;
                  rsp_dist_in  = '0;
               end else begin
                  va_in    = v1c;
                  vb_in    = v2c;
                  state_in = S_QSWAP;
               end
            end
         end
         S_LFILL: begin
            tbl_we = 1'b1;
            ra_vtx = rd_a;
            if (lv_ff == LW'(1)) begin
               dep_we = 1'b1;
               if (dz_b_ff) begin
                  dep_wd = '0;
               end
            end
            if (lv_ff == LW'(LEVELS)) begin
               state_in = S_IDLE;
            end else begin
               lv_in = lv_ff + LW'(1);
            end
         end
         S_QSWAP: begin
            if (da < db) begin
               va_in    = vb_ff;
               vb_in    = va_ff;
               delta_in = db - da;
            end else begin
               delta_in = da - db;
            end
            cnt_in   = DIST_W'(delta_in);
            lv_in    = LW'(LEVELS);
            state_in = S_LIFT;
         end
         S_LIFT: begin
            va_in        = a_cur;
            pend_lift_in = delta_sh[0];
            if (lv_ff == '0) begin
               lv_in    = LW'(LEVELS);
               state_in = S_CLIMB;
            end else begin
               lv_in = lv_ff - LW'(1);
            end
         end
         S_CLIMB: begin
            va_in         = a_cur;
            vb_in         = b_cur;
            cnt_in        = cnt_cur;
            pend_climb_in = 1'b1;
            lvp_in        = lv_ff;
            if (lv_ff == '0) begin
               state_in = S_FIN;
            end else begin
               lv_in = lv_ff - LW'(1);
            end
         end
         S_FIN: begin
            rsp_valid_in = 1'b1;
            rsp_dist_in  = (a_cur != b_cur) ? sat(sum_fin) : cnt_cur;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      tz_a_in     = ra_vtx == '0;
      tz_b_in     = b_cur == '0;
      dz_a_in     = v1c == '0;
      dz_b_in     = v2c == '0;
      fwd_in      = tbl_we && (tbl_wa == tbl_ra);
      fwd_data_in = tbl_wd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pend_lift_ff  <= 1'b0;
         pend_climb_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         fwd_ff        <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_lift_ff  <= pend_lift_in;
         pend_climb_ff <= pend_climb_in;
         rsp_valid_ff  <= rsp_valid_in;
         fwd_ff        <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      va_ff       <= va_in;
      vb_ff       <= vb_in;
      delta_ff    <= delta_in;
      cnt_ff      <= cnt_in;
      lv_ff       <= lv_in;
      lvp_ff      <= lvp_in;
      rsp_dist_ff <= rsp_dist_in;
      tz_a_ff     <= tz_a_in;
      tz_b_ff     <= tz_b_in;
      dz_a_ff     <= dz_a_in;
      dz_b_ff     <= dz_b_in;
      fwd_data_ff <= fwd_data_in;
   end

   assign busy         = state_ff != S_IDLE;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = rsp_dist_ff;

   a_pend_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(pend_lift_ff && pend_climb_ff))
      else $error("lift and climb steps pending together");

   a_fin_responds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN) |=> rsp_valid_ff)
      else $error("closing cycle gave no result");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == S_FIN ||
                             (start && !busy && req_opcode == OP_QUERY)))
      else $error("result without a query");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LIFT || state_ff == S_CLIMB || state_ff == S_LFILL)
         |-> (lv_ff <= LW'(LEVELS)))
      else $error("level counter out of range");

   a_fwd_from_load: assert property (@(posedge clock) disable iff (reset)
      fwd_ff |-> $past(state_ff == S_IDLE || state_ff == S_LFILL))
      else $error("forwarded word outside a load");

endmodule

`default_nettype wire
